[src/dsic_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsic_pkg: shared types and constants of the deadband step integral controller
// Field widths, register index codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package dsic_pkg;

    localparam int LEVEL_W    = 24;
    localparam int FREQ_W     = 16;
    localparam int INT_W      = 48;
    localparam int TRIG_W     = INT_W - 1;
    localparam int DB_W       = 15;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (LEVEL_W > TRIG_W) ? LEVEL_W : TRIG_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER     = 3'd7;

    typedef struct packed {
        logic        [DB_W-1:0]     deadband;
        logic signed [LEVEL_W-1:0]  up_step;
        logic signed [LEVEL_W-1:0]  down_step;
        logic        [PERIOD_W-1:0] up_period;
        logic        [PERIOD_W-1:0] down_period;
        logic signed [LEVEL_W-1:0]  max_level;
        logic signed [LEVEL_W-1:0]  min_level;
        logic        [TRIG_W-1:0]   trigger;
    } t_cfg;

    typedef struct packed {
        logic signed [LEVEL_W-1:0]  level;
        logic signed [INT_W-1:0]    integ;
        logic        [PERIOD_W-1:0] period;
        logic        [PERIOD_W-1:0] ticks;
        logic                       was_active;
    } t_state;

endpackage

[src/deadband_step_integral_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_step_integral_controller_top: deadband step integral controller
// Per-tick controller: countdown to an update, integrator of deviation times
// period, deadband step selection, clamped output level.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_stall    i_freq_dev, i_active
//  out       source     o_out_valid / i_out_stall  o_level, o_updated, o_period_now
//  cfg       sink       i_cfg_we (no wait)         i_cfg_idx, i_cfg_wdata
//
//  One item per clock sustained while the output does not stall; an item passes
//  the input register, then the update logic feeding the result register,
//  which also writes state. The throughput is set by the single state update
//  per cycle in dsic_update. Reset is synchronous and active low; settings and
//  state take their reset values directly, with no clearing pass.
//  A stalled output holds the result register; the input register then holds
//  its item and o_in_stall rises until the result is taken.
//
module deadband_step_integral_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [dsic_pkg::FREQ_W-1:0]  i_freq_dev,
    input  logic                                i_active,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dsic_pkg::LEVEL_W-1:0] o_level,
    output logic                                o_updated,
    output logic [dsic_pkg::PERIOD_W-1:0]       o_period_now,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [dsic_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dsic_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import dsic_pkg::*;

    t_cfg                      w_cfg;
    t_state                    r_state;
    t_state                    w_next;
    logic                      w_upd;

    logic                      r_s1_valid;
    logic signed [FREQ_W-1:0]  r_s1_freq;
    logic                      r_s1_active;

    logic                      r_out_valid;
    logic signed [LEVEL_W-1:0] r_out_level;
    logic                      r_out_updated;
    logic [PERIOD_W-1:0]       r_out_period;

    logic                      w_out_free;
    logic                      w_adv;
    logic                      w_in_fire;

    dsic_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    dsic_update u_update (
        .i_cfg      (w_cfg),
        .i_state    (r_state),
        .i_freq_dev (r_s1_freq),
        .i_active   (r_s1_active),
        .o_state    (w_next),
        .o_updated  (w_upd)
    );

    // The result register is free when empty or being taken this cycle;
    // the held input item then moves on and a new one may enter behind it.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_freq   <= i_freq_dev;
            r_s1_active <= i_active;
        end
    end

    // controller state: advance once per item, in item order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level      <= '0;
            r_state.integ      <= '0;
            r_state.period     <= PERIOD_W'(1);
            r_state.ticks      <= PERIOD_W'(1);
            r_state.was_active <= 1'b0;
        end else if (w_adv) begin
            r_state <= w_next;
        end
    end

    // result register: hold while stalled, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_level   <= w_next.level;
            r_out_updated <= w_upd;
            r_out_period  <= w_next.period;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_updated    = r_out_updated;
    assign o_period_now = r_out_period;

    // level is zero whenever the controller is not active
    a_idle_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.was_active |-> (r_state.level == '0))
        else $error("level nonzero while inactive");

    // an update only happens on a tick that continues an active run
    a_update_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_upd) |-> (r_state.was_active && r_s1_active))
        else $error("update outside an active run");

    // after an update the countdown reloads with the period just chosen
    a_reload_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_upd) |=> (r_state.ticks == r_state.period))
        else $error("countdown not reloaded with period in use");

    // every reported result carries the period that the state now holds
    a_out_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (o_out_valid && (o_period_now == r_state.period)))
        else $error("reported period differs from state");

endmodule

[src/dsic_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsic_cfg_regs: configuration register file
// Decodes the write port and holds the eight controller settings.
// ----------------------------------------------------------------------------
module dsic_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dsic_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dsic_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output dsic_pkg::t_cfg                   o_cfg
);
    import dsic_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband    <= '0;
            r_cfg.up_step     <= '0;
            r_cfg.down_step   <= '0;
            r_cfg.up_period   <= PERIOD_W'(1);
            r_cfg.down_period <= PERIOD_W'(1);
            r_cfg.max_level   <= {1'b0, {(LEVEL_W-1){1'b1}}};
            r_cfg.min_level   <= {1'b1, {(LEVEL_W-1){1'b0}}};
            r_cfg.trigger     <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEADBAND:    r_cfg.deadband    <= i_cfg_wdata[DB_W-1:0];
                REG_UP_STEP:     r_cfg.up_step     <= signed'(i_cfg_wdata[LEVEL_W-1:0]);
                REG_DOWN_STEP:   r_cfg.down_step   <= signed'(i_cfg_wdata[LEVEL_W-1:0]);
                REG_UP_PERIOD:   r_cfg.up_period   <= i_cfg_wdata[PERIOD_W-1:0];
                REG_DOWN_PERIOD: r_cfg.down_period <= i_cfg_wdata[PERIOD_W-1:0];
                REG_MAX_LEVEL:   r_cfg.max_level   <= signed'(i_cfg_wdata[LEVEL_W-1:0]);
                REG_MIN_LEVEL:   r_cfg.min_level   <= signed'(i_cfg_wdata[LEVEL_W-1:0]);
                REG_TRIGGER:     r_cfg.trigger     <= i_cfg_wdata[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/dsic_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsic_update: next-state logic for one tick
// Countdown, integrator accumulate with saturation, step choice and clamp.
// ----------------------------------------------------------------------------
module dsic_update (
    input  dsic_pkg::t_cfg                      i_cfg,
    input  dsic_pkg::t_state                    i_state,
    input  logic signed [dsic_pkg::FREQ_W-1:0]  i_freq_dev,
    input  logic                                i_active,
    output dsic_pkg::t_state                    o_state,
    output logic                                o_updated
);
    import dsic_pkg::*;

    localparam int PROD_W = FREQ_W + PERIOD_W + 1;
    localparam int SUM_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int CMP_W  = ((FREQ_W > DB_W) ? FREQ_W : DB_W) + 2;
    localparam int LV_W   = LEVEL_W + 1;

    logic signed [PERIOD_W:0]   w_period_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_sum_ovf;
    logic signed [INT_W-1:0]    w_integ;
    logic signed [INT_W-1:0]    w_trig;
    logic signed [CMP_W-1:0]    w_f_c;
    logic signed [CMP_W-1:0]    w_db_c;
    logic                       w_high;
    logic                       w_low;
    logic                       w_step_up;
    logic                       w_step_dn;
    logic signed [LEVEL_W-1:0]  w_lo;
    logic signed [LEVEL_W-1:0]  w_hi;
    logic signed [LV_W-1:0]     w_lv;
    logic signed [LEVEL_W-1:0]  w_lv_clamped;
    logic [PERIOD_W-1:0]        w_new_period;
    logic                       w_due;

    // integrator accumulate, saturate to the signed integrator range
    assign w_period_s = signed'({1'b0, i_state.period});
    assign w_prod     = w_period_s * i_freq_dev;
    assign w_sum      = SUM_W'(i_state.integ) + SUM_W'(w_prod);
    assign w_sum_ovf  = !((&w_sum[SUM_W-1:INT_W-1]) || (~|w_sum[SUM_W-1:INT_W-1]));
    assign w_integ    = w_sum_ovf ?
                        (w_sum[SUM_W-1] ? {1'b1, {(INT_W-1){1'b0}}}
                                        : {1'b0, {(INT_W-1){1'b1}}})
                        : w_sum[INT_W-1:0];

    // deviation against the band
    assign w_f_c  = CMP_W'(i_freq_dev);
    assign w_db_c = signed'(CMP_W'(i_cfg.deadband));
    assign w_high = w_f_c > w_db_c;
    assign w_low  = w_f_c < -w_db_c;

    assign w_trig    = signed'({1'b0, i_cfg.trigger});
    assign w_step_up = w_high || (!w_low && (w_integ > w_trig));
    assign w_step_dn = !w_high && (w_low || (!(w_integ > w_trig) && (w_integ < -w_trig)));

    assign w_new_period = w_low ? i_cfg.down_period : i_cfg.up_period;

    // level step and clamp between the smaller and larger limit
    assign w_lo = (i_cfg.max_level < i_cfg.min_level) ? i_cfg.max_level : i_cfg.min_level;
    assign w_hi = (i_cfg.max_level < i_cfg.min_level) ? i_cfg.min_level : i_cfg.max_level;
    assign w_lv = LV_W'(i_state.level)
                + (w_step_up ? LV_W'(i_cfg.up_step) :
                   w_step_dn ? LV_W'(i_cfg.down_step) : LV_W'(0));

    always_comb begin
        if (w_lv < LV_W'(w_lo)) begin
            w_lv_clamped = w_lo;
        end else if (w_lv > LV_W'(w_hi)) begin
            w_lv_clamped = w_hi;
        end else begin
            w_lv_clamped = w_lv[LEVEL_W-1:0];
        end
    end

    assign w_due = i_state.ticks <= PERIOD_W'(1);

    always_comb begin
        o_state            = i_state;
        o_state.was_active = i_active;
        o_updated          = 1'b0;
        if (i_active && !i_state.was_active) begin
            o_state.ticks = i_cfg.up_period;
        end else if (i_active) begin
            if (w_due) begin
                o_state.integ  = w_integ;
                o_state.period = w_new_period;
                o_state.ticks  = w_new_period;
                o_state.level  = w_lv_clamped;
                o_updated      = 1'b1;
            end else begin
                o_state.ticks = i_state.ticks - PERIOD_W'(1);
            end
        end else if (i_state.was_active) begin
            o_state.level = '0;
        end
    end

endmodule

[sim/deadband_step_integral_controller_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_step_integral_controller_top_tb: self-checking controller bench
// Sends deviation ticks with random gaps and output stalls. A tracker class
// models the countdown, integrator, deadband step and clamp for every tick,
// then checks each result item field by field in order.
// ----------------------------------------------------------------------------
module deadband_step_integral_controller_top_tb;
    import dsic_pkg::*;

    localparam int FREQ_HI = (1 << (FREQ_W - 1)) - 1;
    localparam int FREQ_LO = -(1 << (FREQ_W - 1));

    // settings for the directed opening: small periods, a narrow band and
    // a tight clamp so every branch shows up within a couple dozen ticks
    localparam t_cfg DIR_CFG = '{
        deadband:    15'd100,
        up_step:     24'sd1000,
        down_step:   -24'sd1500,
        up_period:   16'd2,
        down_period: 16'd3,
        max_level:   24'sd2500,
        min_level:   -24'sd4000,
        trigger:     47'd5000
    };

    // directed ticks: held inactive, rising edge, both deviation extremes,
    // band edges on each side, falling edge, held inactive, restart, and a
    // run of high deviations that drives the level into the top clamp
    logic signed [FREQ_W-1:0] dir_freq [25] = '{
        0, 32767, 32767, 32767, -32768, -32768, 100, 100, 100, -100,
        -100, 101, 101, -101, -101, -101, 0, 0, 123, 32767,
        32767, 32767, 32767, 32767, 32767
    };
    bit dir_on [25] = '{
        0, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 0, 0, 1, 1,
        1, 1, 1, 1, 1
    };

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      updated;
        logic [PERIOD_W-1:0]       period;
    } t_tick_result;

    // Tracks the controller state tick by tick and holds the results due.
    class t_level_tracker;
        t_cfg                      regs;
        logic signed [LEVEL_W-1:0] lvl;
        logic signed [INT_W-1:0]   acc;
        logic [PERIOD_W-1:0]       period;
        logic [PERIOD_W-1:0]       ticks;
        bit                        was_on;
        t_tick_result              due_ticks[$];
        int                        n_errors;
        int                        n_ticks;
        int                        n_updates;

        function new();
            regs.deadband    = '0;
            regs.up_step     = '0;
            regs.down_step   = '0;
            regs.up_period   = 16'd1;
            regs.down_period = 16'd1;
            regs.max_level   = {1'b0, {(LEVEL_W-1){1'b1}}};
            regs.min_level   = {1'b1, {(LEVEL_W-1){1'b0}}};
            regs.trigger     = '1;
            lvl       = '0;
            acc       = '0;
            period    = 16'd1;
            ticks     = 16'd1;
            was_on    = 1'b0;
            n_errors  = 0;
            n_ticks   = 0;
            n_updates = 0;
        endfunction

        // accumulate, pick the step and the next period, clamp the level
        function void step_level(logic signed [FREQ_W-1:0] f);
            longint fv, db, trig, ia, pv, us, ds, a, b, lo, hi, lv, imax;
            fv   = f;
            db   = regs.deadband;
            trig = regs.trigger;
            ia   = acc;
            pv   = period;
            us   = regs.up_step;
            ds   = regs.down_step;
            a    = regs.max_level;
            b    = regs.min_level;
            lv   = lvl;
            imax = (longint'(1) << (INT_W - 1)) - 1;
            lo   = (a < b) ? a : b;
            hi   = (a < b) ? b : a;

            ia = ia + fv * pv;
            if (ia > imax) ia = imax;
            if (ia < -imax - 1) ia = -imax - 1;
            acc = ia;

            if (fv > db) begin
                lv += us;
                period = regs.up_period;
            end else if (fv < -db) begin
                lv += ds;
                period = regs.down_period;
            end else begin
                period = regs.up_period;
                if (ia > trig) lv += us;
                else if (ia < -trig) lv += ds;
            end
            if (lv < lo) lv = lo;
            if (lv > hi) lv = hi;
            lvl = lv;
        endfunction

        // note one accepted tick and queue the result it must produce
        function void take_tick(logic signed [FREQ_W-1:0] f, bit on);
            t_tick_result r;
            r.updated = 1'b0;
            if (on && !was_on) begin
                ticks = regs.up_period;
            end else if (on) begin
                if (ticks <= 1) begin
                    step_level(f);
                    ticks     = period;
                    r.updated = 1'b1;
                    n_updates++;
                end else begin
                    ticks -= 1;
                end
            end else if (was_on) begin
                lvl = '0;
            end
            was_on   = on;
            r.level  = lvl;
            r.period = period;
            due_ticks.push_back(r);
            n_ticks++;
        endfunction

        function void check_tick(logic signed [LEVEL_W-1:0] level, logic updated,
                                 logic [PERIOD_W-1:0] per);
            t_tick_result want;
            if (due_ticks.size() == 0) begin
                $display("%0t: result with no tick pending: level %0d updated %0b period %0d",
                         $time, level, updated, per);
                n_errors++;
                return;
            end
            want = due_ticks.pop_front();
            if (level !== want.level) begin
                $display("%0t: level mismatch, expected %0d, actual %0d",
                         $time, want.level, level);
                n_errors++;
            end
            if (updated !== want.updated) begin
                $display("%0t: updated mismatch, expected %0b, actual %0b",
                         $time, want.updated, updated);
                n_errors++;
            end
            if (per !== want.period) begin
                $display("%0t: period_now mismatch, expected %0d, actual %0d",
                         $time, want.period, per);
                n_errors++;
            end
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic signed [FREQ_W-1:0]      i_freq_dev   = '0;
    logic                          i_active     = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic signed [LEVEL_W-1:0]     o_level;
    logic                          o_updated;
    logic [PERIOD_W-1:0]           o_period_now;
    logic                          i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_wdata  = '0;

    t_level_tracker track;
    int             src_idle_pct  = 0;
    int             snk_stall_pct = 0;
    int             n_settings    = 0;
    bit             rnd_on        = 1'b1;

    deadband_step_integral_controller_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_freq_dev   (i_freq_dev),
        .i_active     (i_active),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_level      (o_level),
        .o_updated    (o_updated),
        .o_period_now (o_period_now),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver side: stall at the current rate, changing only at the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < snk_stall_pct);
    end

    // take every accepted result at the rising edge and check it
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            track.check_tick(o_level, o_updated, o_period_now);
    end

    // hold the write enable across back-to-back writes; lower it only once
    // the whole set is in, so it never toggles within one time step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    // write all eight registers while the block is idle
    task automatic apply_cfg(input t_cfg c);
        write_reg(REG_DEADBAND,    CFG_DATA_W'(c.deadband));
        write_reg(REG_UP_STEP,     CFG_DATA_W'($unsigned(c.up_step)));
        write_reg(REG_DOWN_STEP,   CFG_DATA_W'($unsigned(c.down_step)));
        write_reg(REG_UP_PERIOD,   CFG_DATA_W'(c.up_period));
        write_reg(REG_DOWN_PERIOD, CFG_DATA_W'(c.down_period));
        write_reg(REG_MAX_LEVEL,   CFG_DATA_W'($unsigned(c.max_level)));
        write_reg(REG_MIN_LEVEL,   CFG_DATA_W'($unsigned(c.min_level)));
        write_reg(REG_TRIGGER,     CFG_DATA_W'(c.trigger));
        i_cfg_we   <= 1'b0;
        track.regs  = c;
        n_settings++;
    endtask

    // settings per phase: moderate random, the extremes, or zero periods with
    // the widest trigger and no deadband
    function automatic t_cfg make_cfg(input int kind);
        t_cfg c;
        c.deadband    = DB_W'($urandom_range(3000));
        c.up_step     = LEVEL_W'(int'($urandom_range(40000)) - 20000);
        c.down_step   = LEVEL_W'(int'($urandom_range(40000)) - 20000);
        c.up_period   = PERIOD_W'($urandom_range(5, 1));
        c.down_period = PERIOD_W'($urandom_range(5, 1));
        c.max_level   = LEVEL_W'(int'($urandom_range(100000)) - 50000);
        c.min_level   = LEVEL_W'(int'($urandom_range(100000)) - 50000);
        c.trigger     = TRIG_W'($urandom_range(300000));
        if (kind == 1) begin
            // limits swapped on purpose: min_level holds the top
            c.deadband    = '1;
            c.up_step     = {1'b0, {(LEVEL_W-1){1'b1}}};
            c.down_step   = {1'b1, {(LEVEL_W-1){1'b0}}};
            c.up_period   = 16'd1;
            c.down_period = '1;
            c.max_level   = {1'b1, {(LEVEL_W-1){1'b0}}};
            c.min_level   = {1'b0, {(LEVEL_W-1){1'b1}}};
            c.trigger     = '0;
        end else if (kind == 2) begin
            c.deadband    = '0;
            c.up_period   = '0;
            c.down_period = '0;
            c.trigger     = '1;
        end
        return c;
    endfunction

    // deviation mix: anything, inside the band, right on its edges, just outside
    function automatic logic signed [FREQ_W-1:0] pick_freq(input int db);
        int v;
        int sel;
        sel = $urandom_range(3);
        if (sel == 0) return FREQ_W'($urandom);
        case (sel)
            1: v = int'($urandom_range(2 * db)) - db;
            2: begin
                case ($urandom_range(3))
                    0:       v = db;
                    1:       v = db + 1;
                    2:       v = -db;
                    default: v = -db - 1;
                endcase
            end
            default: begin
                v = db + 1 + int'($urandom_range(600));
                if ($urandom_range(1) != 0) v = -v;
            end
        endcase
        if (v > FREQ_HI) v = FREQ_HI;
        if (v < FREQ_LO) v = FREQ_LO;
        return FREQ_W'(v);
    endfunction

    // offer one tick: idle first at the sender rate, then hold it until taken
    task automatic send_item(input logic signed [FREQ_W-1:0] f, input bit on);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_freq_dev <= f;
        i_active   <= on;
        do @(posedge i_clk); while (o_in_stall);
        track.take_tick(f, on);
        @(negedge i_clk);
    endtask

    // one phase: write settings, send ticks, drain every result before the next
    task automatic run_phase(input t_cfg c, input int src_pct, input int snk_pct,
                             input int n, input bit directed);
        apply_cfg(c);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int k = 0; k < n; k++) begin
            if (directed) begin
                send_item(dir_freq[k], dir_on[k]);
            end else begin
                // mostly long active runs so the countdown expires often;
                // flip now and then for edges and inactive stretches
                if ($urandom_range(99) < 4) rnd_on = !rnd_on;
                send_item(pick_freq(track.regs.deadband), rnd_on);
            end
        end
        i_in_valid <= 1'b0;
        while (track.due_ticks.size() != 0) @(negedge i_clk);
        // let the two-stage pipe settle before the next register writes
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        track = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(DIR_CFG,     0,  0,  25, 1'b1);
        run_phase(make_cfg(0), 0,  0,  75, 1'b0);
        run_phase(make_cfg(1), 65, 0,  75, 1'b0);
        run_phase(make_cfg(2), 0,  65, 75, 1'b0);
        run_phase(make_cfg(0), 14, 14, 75, 1'b0);
        run_phase(make_cfg(0), 65, 0,  75, 1'b0);
        run_phase(make_cfg(0), 0,  65, 75, 1'b0);

        $display("Checked %0d ticks, %0d of them update steps, over %0d register settings",
                 track.n_ticks, track.n_updates, n_settings);
        $display("Idle patterns: none, sender gaps, receiver stalls, and both together");
        if (track.n_errors == 0 && track.due_ticks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
